// ----- sv/sda_pkg.sv -----
package sda_pkg;

   // Angle resolution and iteration count
   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int TABLE_LEN       = 24;
   localparam int NUM_STEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   // Field widths
   localparam int SENSOR_W  = 10;
   localparam int BEARING_W = 15;
   localparam int REQ_W     = 4 * SENSOR_W;
   localparam int RSP_W     = ((BEARING_W + 7) / 8) * 8;

   // Internal fixed-point formats
   localparam int SUM_W          = SENSOR_W + 2;   // signed difference of two pair sums
   localparam int PRESCALE_SHIFT = 12;
   localparam int XY_W           = SUM_W + PRESCALE_SHIFT + 4;
   localparam int ACC_FRAC       = 20;
   localparam int Z_W            = 30;
   localparam int T_W            = 31;
   localparam int RND_SHIFT      = ACC_FRAC - ANGLE_FRAC_BITS;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [XY_W-1:0]  xy_type;
   typedef logic signed [Z_W-1:0]   z_type;
   typedef logic signed [T_W-1:0]   t_type;
   typedef logic        [T_W-1:0]   r_type;

   localparam z_type DEG90  = z_type'(90 * (2 ** ACC_FRAC));
   localparam t_type DEG270 = t_type'(270 * (2 ** ACC_FRAC));
   localparam t_type DEG360 = t_type'(360 * (2 ** ACC_FRAC));
   localparam r_type RND_HALF = r_type'(2 ** (RND_SHIFT - 1));
   localparam r_type BEARING_LIMIT = r_type'(360 * (2 ** ANGLE_FRAC_BITS));

   // atan(2^-i) in degrees times 2^20, rounded to nearest
   localparam z_type ATAN_TABLE [TABLE_LEN] = '{
      30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
      30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
      30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
      30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
      30'sd917,      30'sd458,      30'sd229,      30'sd115,
      30'sd57,       30'sd29,       30'sd14,       30'sd7
   };

endpackage

// ----- sv/sun_direction_angle.sv -----
// Sun bearing from four photodiode readings.
//
// Input channel (req_): one transaction carries the four 10-bit sensor
// readings. The block forms x = (b + c) - (a + d) and y = (a + b) - (c + d),
// finds the angle of (x, y) with an unrolled CORDIC vectoring pipeline and
// returns the clockwise bearing (270 - angle) mod 360 in degrees times 64.
// Result channel (rsp_): one transaction per input transaction, in order.
// rsp_tuser is the dark flag: both components zero, bearing then reads 0.
//
// Pipeline: NUM_STEPS + 4 register stages (20 with 16 CORDIC steps): sum
// stage, quadrant pre-rotation stage, one stage per CORDIC micro-rotation,
// wrap stage and rounding/output stage. Throughput: one transaction per
// cycle unless stalled; each stage holds one item.
// Stall: when the receiver holds rsp_tready low with a result pending, the
// whole pipeline freezes and req_tready drops; nothing is lost or repeated.
// Reset clears every valid bit; the pipeline comes up empty and ready.
module sun_direction_angle
   import sda_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // sensor_a, sensor_b, sensor_c, sensor_d
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // bearing, zero fill
   output logic             rsp_tuser    // dark
);

   // Global advance: the output register is empty or being drained
   logic advance;
   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   // ---------------------------------------------------------------------
   // Stage S: unpack and form the two signed sums
   // ---------------------------------------------------------------------
   logic [SENSOR_W-1:0] sensor_a, sensor_b, sensor_c, sensor_d;
   assign sensor_a = req_tdata[0*SENSOR_W +: SENSOR_W];
   assign sensor_b = req_tdata[1*SENSOR_W +: SENSOR_W];
   assign sensor_c = req_tdata[2*SENSOR_W +: SENSOR_W];
   assign sensor_d = req_tdata[3*SENSOR_W +: SENSOR_W];

   sum_type sum_x_in, sum_y_in;
   sum_type sum_x_ff, sum_y_ff;
   logic    sum_valid_ff;

   always_comb begin
      sum_x_in = sum_type'({2'b00, sensor_b}) + sum_type'({2'b00, sensor_c})
               - sum_type'({2'b00, sensor_a}) - sum_type'({2'b00, sensor_d});
      sum_y_in = sum_type'({2'b00, sensor_a}) + sum_type'({2'b00, sensor_b})
               - sum_type'({2'b00, sensor_c}) - sum_type'({2'b00, sensor_d});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= req_tvalid;
      end
      if (advance) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
   end

   // ---------------------------------------------------------------------
   // CORDIC pipeline: entry 0 is the pre-rotated vector, entry k is the
   // vector after micro-rotation k-1
   // ---------------------------------------------------------------------
   xy_type cx_in    [NUM_STEPS+1];
   xy_type cy_in    [NUM_STEPS+1];
   z_type  cz_in    [NUM_STEPS+1];
   xy_type cx_ff    [NUM_STEPS+1];
   xy_type cy_ff    [NUM_STEPS+1];
   z_type  cz_ff    [NUM_STEPS+1];
   logic   cdark_ff [NUM_STEPS+1];
   logic   cvalid_ff[NUM_STEPS+1];

   // Pre-rotation: scale up, then fold the left half-plane by +/-90 degrees
   xy_type pre_x, pre_y;
   logic   pre_dark;

   always_comb begin
      pre_x    = xy_type'(sum_x_ff) <<< PRESCALE_SHIFT;
      pre_y    = xy_type'(sum_y_ff) <<< PRESCALE_SHIFT;
      pre_dark = (sum_x_ff == '0) && (sum_y_ff == '0);
      cx_in[0] = pre_x;
      cy_in[0] = pre_y;
      cz_in[0] = '0;
      if (pre_x < 0) begin
         if (pre_y >= 0) begin
            cx_in[0] = pre_y;
            cy_in[0] = -pre_x;
            cz_in[0] = DEG90;
         end else begin
            cx_in[0] = -pre_y;
            cy_in[0] = pre_x;
            cz_in[0] = -DEG90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff[0] <= 1'b0;
      end else if (advance) begin
         cvalid_ff[0] <= sum_valid_ff;
      end
      if (advance) begin
         cx_ff[0]    <= cx_in[0];
         cy_ff[0]    <= cy_in[0];
         cz_ff[0]    <= cz_in[0];
         cdark_ff[0] <= pre_dark;
      end
   end

   // One micro-rotation per stage; arithmetic shift gives floor rounding
   for (genvar k = 1; k <= NUM_STEPS; k++) begin : g_step
      always_comb begin
         if (cy_ff[k-1] > 0) begin
            cx_in[k] = cx_ff[k-1] + (cy_ff[k-1] >>> (k - 1));
            cy_in[k] = cy_ff[k-1] - (cx_ff[k-1] >>> (k - 1));
            cz_in[k] = cz_ff[k-1] + ATAN_TABLE[k-1];
         end else begin
            cx_in[k] = cx_ff[k-1] - (cy_ff[k-1] >>> (k - 1));
            cy_in[k] = cy_ff[k-1] + (cx_ff[k-1] >>> (k - 1));
            cz_in[k] = cz_ff[k-1] - ATAN_TABLE[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cvalid_ff[k] <= 1'b0;
         end else if (advance) begin
            cvalid_ff[k] <= cvalid_ff[k-1];
         end
         if (advance) begin
            cx_ff[k]    <= cx_in[k];
            cy_ff[k]    <= cy_in[k];
            cz_ff[k]    <= cz_in[k];
            cdark_ff[k] <= cdark_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Wrap stage: bearing = 270 - angle, folded into [0, 360)
   // ---------------------------------------------------------------------
   t_type turn_raw, turn_in, turn_ff;
   logic  turn_valid_ff, turn_dark_ff;

   always_comb begin
      turn_raw = DEG270 - t_type'(cz_ff[NUM_STEPS]);
      if (turn_raw < 0) begin
         turn_in = turn_raw + DEG360;
      end else if (turn_raw >= DEG360) begin
         turn_in = turn_raw - DEG360;
      end else begin
         turn_in = turn_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_valid_ff <= 1'b0;
      end else if (advance) begin
         turn_valid_ff <= cvalid_ff[NUM_STEPS];
      end
      if (advance) begin
         turn_ff      <= turn_in;
         turn_dark_ff <= cdark_ff[NUM_STEPS];
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: round half up to the output resolution, map 360 and dark to 0
   // ---------------------------------------------------------------------
   r_type                rnd_sum, rnd_val;
   logic [BEARING_W-1:0] bearing_in, bearing_ff;
   logic                 rsp_valid_ff, dark_ff;

   always_comb begin
      rnd_sum = r_type'(turn_ff) + RND_HALF;
      rnd_val = rnd_sum >> RND_SHIFT;
      if (turn_dark_ff || (rnd_val >= BEARING_LIMIT)) begin
         bearing_in = '0;
      end else begin
         bearing_in = rnd_val[BEARING_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= turn_valid_ff;
      end
      if (advance) begin
         bearing_ff <= bearing_in;
         dark_ff    <= turn_dark_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(bearing_ff);
   assign rsp_tuser  = dark_ff;

endmodule
